@@ rtl/core/binary_thinning_subpass_macros.svh @@
// Assertion macros used by the checker file of the thinning sub-pass block.
// Depends on nothing; included by bare file name.
`ifndef BINARY_THINNING_SUBPASS_MACROS_SVH
`define BINARY_THINNING_SUBPASS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bts_pkg.sv @@
// Package of the thinning sub-pass block: sizes, register codes, result type
// and the four keep tables. Depends on nothing.
package bts_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COORD_W    = 12;
    localparam int SIZE_W     = 13;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int RES_SLOTS  = 4;
    localparam int CNT_W      = $clog2(RES_SLOTS + 1);
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;
    localparam int MIN_SIZE   = 3;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

    typedef enum logic [1:0] {
        REG_ALGORITHM,
        REG_SUBPASS,
        REG_WIDTH,
        REG_HEIGHT
    } reg_idx_t;

    typedef struct packed {
        logic               pixel_out;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic               pixel_changed;
        logic               run_last;
        logic               frame_end;
        logic               frame_changed;
    } res_t;

    // Keep tables; index 0 of each vector is neighbour code 0.
    // Order: Zhang-Suen pass 0, Zhang-Suen pass 1, Guo-Hall pass 0, Guo-Hall pass 1.
    localparam logic [0:255] KEEP_ROM [4] = '{
        {
            37'b11101100_11110100_11111111_01110100_11111,
            37'b11111111_11101111_11101110_11111111_11111,
            37'b11111111_11111111_11110111_11111111_11111,
            37'b10111111_10111011_11010111_01111111_01111,
            37'b11111111_11101111_11111111_11111111_11111,
            37'b11111110_01011101_11111101_11111111_11111,
            34'b11001011_10111111_11001011_11111111_11
        },
        {
            37'b11101100_11110100_11111111_01110100_11111,
            37'b11111111_11101111_11101110_10011111_11111,
            37'b11111111_11111111_11110111_11111111_11111,
            37'b10111111_10111010_11010111_01111111_11111,
            37'b11111111_11111111_11111111_11111111_11111,
            37'b11111110_01011101_11111111_11111111_11111,
            34'b11001111_11111111_11001111_11001101_11
        },
        {
            37'b11111110_11001100_11111111_11000100_11111,
            37'b11101000_10011111_11101000_10011111_11111,
            37'b11111111_11111111_11111111_11111101_01010,
            37'b10111111_10101010_11110111_01110111_01111,
            37'b11111110_11101111_11111111_11111111_11111,
            37'b11111111_11111111_11111111_11111111_11111,
            34'b11111111_11111111_11111111_11111111_11
        },
        {
            37'b11111110_11111111_11111111_11111111_11111,
            37'b11111111_11111111_11101111_11111111_11111,
            37'b11111111_11111111_11111111_11111111_11111,
            37'b10111111_10111111_11100110_01111111_11111,
            37'b11111111_11110000_11001111_11110000_11110,
            37'b01111111_00011001_11111111_11111111_11111,
            34'b11000011_00111111_11000011_11001111_11
        }
    };

    function automatic logic keep_bit(logic [1:0] sel, logic [7:0] code);
        return KEEP_ROM[sel][code];
    endfunction

endpackage

@@ rtl/core/bts_if.sv @@
// Valid/ready channel interfaces of the thinning sub-pass block, one for
// input pixels and one for results. Depends on bts_pkg.
interface bts_in_if;
    logic valid;
    logic ready;
    logic pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bts_out_if;
    import bts_pkg::*;

    logic               valid;
    logic               ready;
    logic               pixel_out;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               pixel_changed;
    logic               run_last;
    logic               frame_end;
    logic               frame_changed;

    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output pixel_changed, output run_last, output frame_end,
                    output frame_changed, input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_col,
                    input pixel_changed, input run_last, input frame_end,
                    input frame_changed, output ready);
endinterface

@@ rtl/core/bts_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bts_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/binary_thinning_subpass.sv @@
// Thinning sub-pass top level. Depends on bts_pkg, bts_if and bts_ram.
// The first result of an item is shown in the cycle after the item is accepted.
// Throughput: one item per cycle while the output is ready; an item that ends a row or lies
// on the last row holds the input while its one to three extra results drain.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes all 4096 entries of
// the line store, during which no item is accepted (register writes are taken).
module binary_thinning_subpass (
    input  logic                        clk,
    input  logic                        rst_n,
    bts_in_if.sink                      in_ch,
    bts_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bts_pkg::APB_AW-1:0]  paddr,
    input  logic [bts_pkg::APB_DW-1:0]  pwdata,
    output logic [bts_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import bts_pkg::*;

    // Configuration registers.
    logic              alg_reg;
    logic              sub_reg;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic              cfg_we;
    reg_idx_t          cfg_idx;

    // Clearing pass over the line store after reset.
    logic              clear_busy_reg;
    logic [ADDR_W-1:0] clear_addr_reg;

    // Raster position, 3x3 window and the frame's change flag.
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_next;
    logic [COORD_W-1:0] col_next;
    logic [8:0]         win_reg;
    logic [8:0]         win_next;
    logic               any_chg_reg;
    logic               any_chg_next;

    // Result bank: slot 0 is the one shown on the output channel.
    res_t               res_reg [RES_SLOTS];
    res_t               res_next [RES_SLOTS];
    res_t               new_res [RES_SLOTS];
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   new_cnt;

    // Line store: bit 1 holds the previous row, bit 0 the row before it.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [1:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [1:0]        ram_rdata;

    logic               in_fire;
    logic               out_fire;
    logic [SIZE_W-1:0]  w_clamp;
    logic [SIZE_W-1:0]  h_clamp;
    logic [COORD_W-1:0] wm1;
    logic [COORD_W-1:0] hm1;
    logic               last_col;
    logic               last_row;
    logic               interior;
    logic               emits;
    logic [7:0]         code;
    logic               val_a;
    logic [COORD_W-1:0] row_m1;
    logic [COORD_W-1:0] col_m1;
    res_t               slot_a;
    res_t               slot_b;
    res_t               slot_c;
    res_t               slot_d;
    logic               frame_chg;

    function automatic res_t make_res(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                                      logic val, logic orig);
        res_t r;
        r.pixel_out     = val;
        r.out_row       = row;
        r.out_col       = col;
        r.pixel_changed = orig & ~val;
        r.run_last      = 1'b0;
        r.frame_end     = 1'b0;
        r.frame_changed = 1'b0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // APB register port. Writes complete in the access cycle; reads are
    // returned combinationally from the register selected by paddr.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_ALGORITHM: prdata = APB_DW'(alg_reg);
            REG_SUBPASS:   prdata = APB_DW'(sub_reg);
            REG_WIDTH:     prdata = APB_DW'(width_reg);
            REG_HEIGHT:    prdata = APB_DW'(height_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alg_reg    <= 1'b0;
            sub_reg    <= 1'b0;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_ALGORITHM: alg_reg    <= pwdata[0];
                REG_SUBPASS:   sub_reg    <= pwdata[0];
                REG_WIDTH:     width_reg  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT:    height_reg <= pwdata[SIZE_W-1:0];
                default:       alg_reg    <= alg_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Image size, clamped to the supported range. A row or column count
    // at or past the last index counts as the last one, so shrinking the
    // size mid-frame closes the current row or frame at once.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (width_reg < SIZE_W'(MIN_SIZE))
        begin
            w_clamp = SIZE_W'(MIN_SIZE);
        end
        else if (width_reg > SIZE_W'(MAX_WIDTH))
        begin
            w_clamp = SIZE_W'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = width_reg;
        end

        if (height_reg < SIZE_W'(MIN_SIZE))
        begin
            h_clamp = SIZE_W'(MIN_SIZE);
        end
        else if (height_reg > SIZE_W'(MAX_HEIGHT))
        begin
            h_clamp = SIZE_W'(MAX_HEIGHT);
        end
        else
        begin
            h_clamp = height_reg;
        end

        wm1 = COORD_W'(w_clamp - SIZE_W'(1));
        hm1 = COORD_W'(h_clamp - SIZE_W'(1));
    end

    assign last_col = (col_reg >= wm1);
    assign last_row = (row_reg >= hm1);

    // ------------------------------------------------------------------
    // Handshakes. The bank is reloaded by an item only when it is empty
    // or its last result leaves in the same cycle, so in_ch.ready follows
    // out_ch.ready combinationally in that one case.
    // ------------------------------------------------------------------
    assign out_ch.valid = (cnt_reg != '0);
    assign out_fire     = out_ch.valid && out_ch.ready;
    assign in_ch.ready  = !clear_busy_reg &&
                          ((cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_ch.ready));
    assign in_fire      = in_ch.valid && in_ch.ready;

    assign out_ch.pixel_out     = res_reg[0].pixel_out;
    assign out_ch.out_row       = res_reg[0].out_row;
    assign out_ch.out_col       = res_reg[0].out_col;
    assign out_ch.pixel_changed = res_reg[0].pixel_changed;
    assign out_ch.run_last      = res_reg[0].run_last;
    assign out_ch.frame_end     = res_reg[0].frame_end;
    assign out_ch.frame_changed = res_reg[0].frame_changed;

    // ------------------------------------------------------------------
    // Line store. The read port always prefetches the column of the next
    // item, so its registered data is ready when that item arrives. While
    // an item is accepted the read moves on to the following column and the
    // write goes to the current one; the two never collide because the last
    // column is at least column two.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + COORD_W'(1);
        end
        else
        begin
            col_next = col_reg + COORD_W'(1);
            row_next = row_reg;
        end
    end

    always_comb
    begin
        if (clear_busy_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_addr_reg;
            ram_wdata = 2'b00;
        end
        else
        begin
            ram_we    = in_fire;
            ram_waddr = ADDR_W'(col_reg);
            ram_wdata = {in_ch.pixel_in, ram_rdata[1]};
        end
        ram_raddr = in_fire ? ADDR_W'(col_next) : ADDR_W'(col_reg);
    end

    bts_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Window and results. The window shifts one column per item; its
    // newest column holds the current pixel on top of the two stored rows.
    // The centre of the window is pixel (row-1, col-1). Only an interior
    // foreground centre consults the keep table; every other result is 0.
    // ------------------------------------------------------------------
    assign win_next = {in_ch.pixel_in, ram_rdata[1], ram_rdata[0], win_reg[8:3]};
    assign code     = {win_next[1], win_next[2], win_next[5], win_next[8],
                       win_next[7], win_next[6], win_next[3], win_next[0]};
    assign interior = (row_reg >= COORD_W'(2)) && (row_reg <= hm1) &&
                      (col_reg >= COORD_W'(2)) && (col_reg <= wm1);
    assign val_a    = interior && win_next[4] && keep_bit({alg_reg, sub_reg}, code);
    assign row_m1   = row_reg - COORD_W'(1);
    assign col_m1   = col_reg - COORD_W'(1);
    assign emits    = (row_reg != '0) && (col_reg != '0);

    always_comb
    begin
        // Raster order: the centre, then the right border pixel of the row
        // above on the last column, then the bottom row pixels on the last row.
        slot_a = make_res(row_m1, col_m1, val_a, win_next[4]);
        slot_b = make_res(row_m1, col_reg, 1'b0, win_next[7]);
        slot_c = make_res(row_reg, col_m1, 1'b0, win_next[5]);
        slot_d = make_res(row_reg, col_reg, 1'b0, win_next[8]);

        frame_chg = any_chg_reg | slot_a.pixel_changed | slot_b.pixel_changed |
                    slot_c.pixel_changed | slot_d.pixel_changed;

        if (!emits)
        begin
            new_cnt = '0;
        end
        else if (last_col && last_row)
        begin
            new_cnt = CNT_W'(RES_SLOTS);
        end
        else
        begin
            new_cnt = CNT_W'(1) + CNT_W'(last_col) + CNT_W'(last_row);
        end

        new_res[0] = slot_a;
        new_res[1] = last_col ? slot_b : slot_c;
        new_res[2] = slot_c;
        new_res[3] = slot_d;
        for (int i = 0; i < RES_SLOTS - 1; i++)
        begin
            new_res[i].run_last = (CNT_W'(i + 1) == new_cnt);
        end
        // The fourth slot only exists on the frame's last pixel.
        new_res[3].run_last      = 1'b1;
        new_res[3].frame_end     = 1'b1;
        new_res[3].frame_changed = frame_chg;

        if (last_col && last_row)
        begin
            any_chg_next = 1'b0;
        end
        else if (emits)
        begin
            any_chg_next = any_chg_reg | slot_a.pixel_changed |
                           (last_col & slot_b.pixel_changed) |
                           (last_row & slot_c.pixel_changed);
        end
        else
        begin
            any_chg_next = any_chg_reg;
        end
    end

    // Bank update: a new item replaces the bank, otherwise a taken result
    // shifts the remaining ones down.
    always_comb
    begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (in_fire)
        begin
            res_next = new_res;
            cnt_next = new_cnt;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < RES_SLOTS - 1; i++)
            begin
                res_next[i] = res_reg[i + 1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            win_reg        <= '0;
            any_chg_reg    <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (clear_busy_reg)
            begin
                clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
                if (clear_addr_reg == ADDR_W'(MAX_WIDTH - 1))
                begin
                    clear_busy_reg <= 1'b0;
                end
            end
            if (in_fire)
            begin
                row_reg     <= row_next;
                col_reg     <= col_next;
                win_reg     <= win_next;
                any_chg_reg <= any_chg_next;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ rtl/core/bts_checker.sv @@
// Port-level checker for the thinning sub-pass block, bound to its top level.
// Depends on binary_thinning_subpass_macros.svh and bts_pkg.
`include "binary_thinning_subpass_macros.svh"

module bts_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        pixel_out,
    input logic [bts_pkg::COORD_W-1:0] out_row,
    input logic [bts_pkg::COORD_W-1:0] out_col,
    input logic                        pixel_changed,
    input logic                        run_last,
    input logic                        frame_end,
    input logic                        frame_changed
);
    import bts_pkg::*;

    // A frame change flag is only reported on the frame's closing result.
    `BTS_ASSERT_NOW(a_chg_flag_on_end, clk, rst_n, out_valid && frame_changed, frame_end, "frame_changed outside frame end")

    // The closing result of a frame is also the last result of its item.
    `BTS_ASSERT_NOW(a_end_is_run_last, clk, rst_n, out_valid && frame_end, run_last, "frame_end without run_last")

    // A changed pixel was removed, so it leaves as background.
    `BTS_ASSERT_NOW(a_changed_is_zero, clk, rst_n, out_valid && pixel_changed, !pixel_out, "changed pixel is not zero")

    // A stalled result keeps its position and value.
    `BTS_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_row) && $stable(out_col) && $stable(pixel_out), "stalled result changed")

endmodule

bind binary_thinning_subpass bts_checker u_bts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .pixel_out     (out_ch.pixel_out),
    .out_row       (out_ch.out_row),
    .out_col       (out_ch.out_col),
    .pixel_changed (out_ch.pixel_changed),
    .run_last      (out_ch.run_last),
    .frame_end     (out_ch.frame_end),
    .frame_changed (out_ch.frame_changed)
);
